[sv/sfb_pkg.sv]
// Shared constants, codes and the node table helper for the sigmoid forward/backward unit.
package sfb_pkg;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 32;

	localparam logic ACT_FWD = 1'b0;
	localparam logic ACT_BWD = 1'b1;

	localparam logic [15:0] Y_ONE     = 16'hFFFF;
	localparam logic [31:0] HALF_DEN  = 32'd2147418112;
	localparam logic [31:0] DEN       = 32'd4294836225;
	localparam logic [15:0] GRAD_PMAX = 16'h7FFF;
	localparam logic [15:0] GRAD_NMAX = 16'h8000;
	localparam logic [63:0] Q31_ONE   = 64'h0000_0000_8000_0000;

	// exp(-t) in Q31 from a short series at t/256 and eight squarings
	function automatic logic [63:0] exp_neg_q31(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] u3;
		logic [63:0] u4;
		logic [63:0] r;
		u  = t >> 8;
		u2 = (u * u) >> 31;
		u3 = (u2 * u) >> 31;
		u4 = (u3 * u) >> 31;
		r  = Q31_ONE - u + (u2 >> 1) - (u3 / 6) + (u4 / 24);
		for (int i = 0; i < 8; i++) begin
			r = (r * r) >> 31;
		end
		return r;
	endfunction

endpackage

[sv/sigmoid_forward_backward.sv]
// Logistic sigmoid unit: forward activation and backward gradient, four-stage pipeline.
// An accepted input passes stage registers s1 to s4 and leaves s4 on the master side.
// Throughput: one per cycle if unstalled; each stage holds one item and moves when the
// stage after it is empty or moving, so bubbles close up under back-pressure.
// Stage work: |x| scaling and y*(1-y), table read and dy*p, interpolation product and
// quotient estimate, rounding/saturation into the output register.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module sigmoid_forward_backward
	import sfb_pkg::*;
#(
	parameter int PWL_SEGMENTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [15:0] x_value, [31:16] saved_output, [47:32] upstream_grad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] action
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] activation_out, [31:16] gradient_out
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int SEG_W = $clog2(PWL_SEGMENTS + 1);
	localparam int P_W   = 16 + SEG_W;
	localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(PWL_SEGMENTS);

	// node table, built at elaboration
	logic [15:0] node_rom [PWL_SEGMENTS+1];

	for (genvar k = 0; k <= PWL_SEGMENTS; k++) begin : g_node
		localparam logic [63:0] T_Q31 = (64'(8 * k) << 31) / PWL_SEGMENTS;
		localparam logic [63:0] D_Q31 = Q31_ONE + exp_neg_q31(T_Q31);
		localparam logic [63:0] NODE  = ((64'd65535 << 31) + (D_Q31 >> 1)) / D_Q31;
		assign node_rom[k] = NODE[15:0];
	end

	// input fields
	logic        action;
	logic [15:0] x_value;
	logic [15:0] saved_output;
	logic [15:0] upstream_grad;

	assign action        = s_axis_tuser;
	assign x_value       = s_axis_tdata[15:0];
	assign saved_output  = s_axis_tdata[31:16];
	assign upstream_grad = s_axis_tdata[47:32];

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || m_axis_tready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_axis_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1 logic
	logic             xneg_c;
	logic [15:0]      xabs_c;
	logic [P_W-1:0]   xp_c;
	logic             gneg_c;
	logic [15:0]      gmag_c;
	logic [29:0]      py_c;
	logic [31:0]      py_full_c;

	always_comb begin
		xneg_c    = x_value[15];
		xabs_c    = xneg_c ? 16'(-x_value) : x_value;
		xp_c      = P_W'(xabs_c) * P_W'(PWL_SEGMENTS);
		gneg_c    = upstream_grad[15];
		gmag_c    = gneg_c ? 16'(-upstream_grad) : upstream_grad;
		py_full_c = {16'd0, saved_output} * {16'd0, Y_ONE - saved_output};
		py_c      = py_full_c[29:0];
	end

	logic             act_s1, xneg_s1, gneg_s1;
	logic [SEG_W-1:0] seg_s1;
	logic [14:0]      frac_s1;
	logic [15:0]      gmag_s1;
	logic [29:0]      py_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1  <= action;
			xneg_s1 <= xneg_c;
			gneg_s1 <= gneg_c;
			seg_s1  <= SEG_W'(xp_c >> 15);
			frac_s1 <= xp_c[14:0];
			gmag_s1 <= gmag_c;
			py_s1   <= py_c;
		end
	end

	// stage 2 logic: table read and gradient numerator
	logic [SEG_W-1:0] hi_idx_c;
	logic [15:0]      lo_c, hi_c, dlt_c;
	logic [45:0]      num_c;
	logic [45:0]      prod_c;

	always_comb begin
		hi_idx_c = (seg_s1 == SEG_LAST) ? seg_s1 : seg_s1 + SEG_W'(1);
		lo_c     = node_rom[seg_s1];
		hi_c     = node_rom[hi_idx_c];
		dlt_c    = (hi_c > lo_c) ? hi_c - lo_c : 16'd0;
		prod_c   = {30'd0, gmag_s1} * {16'd0, py_s1};
		num_c    = prod_c + 46'(HALF_DEN);
	end

	logic        act_s2, xneg_s2, gneg_s2;
	logic [15:0] lo_s2, dlt_s2;
	logic [14:0] frac_s2;
	logic [45:0] num_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			act_s2  <= act_s1;
			xneg_s2 <= xneg_s1;
			gneg_s2 <= gneg_s1;
			lo_s2   <= lo_c;
			dlt_s2  <= dlt_c;
			frac_s2 <= frac_s1;
			num_s2  <= num_c;
		end
	end

	// stage 3 logic: interpolation product, quotient estimate by 2^32
	logic [30:0] prodf_c;
	logic [13:0] q0_c;
	logic [32:0] rem_c;

	always_comb begin
		prodf_c = {15'd0, dlt_s2} * {16'd0, frac_s2};
		q0_c    = num_s2[45:32];
		// remainder against 65535^2 = 2^32 - 2^17 + 1
		rem_c   = {1'b0, num_s2[31:0]} + 33'({q0_c, 17'd0}) - 33'(q0_c);
	end

	logic        act_s3, xneg_s3, gneg_s3;
	logic [15:0] lo_s3;
	logic [30:0] prodf_s3;
	logic [13:0] q0_s3;
	logic [32:0] rem_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			act_s3   <= act_s2;
			xneg_s3  <= xneg_s2;
			gneg_s3  <= gneg_s2;
			lo_s3    <= lo_s2;
			prodf_s3 <= prodf_c;
			q0_s3    <= q0_c;
			rem_s3   <= rem_c;
		end
	end

	// stage 4 logic: round, clamp, mirror, saturate
	logic [31:0] rnd_c;
	logic [16:0] sf_c;
	logic [15:0] s16_c, yv_c;
	logic [13:0] q_c;
	logic [15:0] qm_c, gv_c;

	always_comb begin
		rnd_c = {1'b0, prodf_s3} + 32'd16384;
		sf_c  = {1'b0, lo_s3} + rnd_c[31:15];
		s16_c = (sf_c > {1'b0, Y_ONE}) ? Y_ONE : sf_c[15:0];
		yv_c  = xneg_s3 ? Y_ONE - s16_c : s16_c;
		q_c   = q0_s3 + 14'(rem_s3 >= {1'b0, DEN});
		if (gneg_s3) begin
			qm_c = ({2'd0, q_c} > GRAD_NMAX) ? GRAD_NMAX : {2'd0, q_c};
			gv_c = 16'(-qm_c);
		end else begin
			qm_c = ({2'd0, q_c} > GRAD_PMAX) ? GRAD_PMAX : {2'd0, q_c};
			gv_c = qm_c;
		end
	end

	logic [15:0] act_out_s4, grad_out_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			act_out_s4  <= (act_s3 == ACT_FWD) ? yv_c : 16'd0;
			grad_out_s4 <= (act_s3 == ACT_BWD) ? gv_c : 16'd0;
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {grad_out_s4, act_out_s4};

endmodule

[sv/sfb_checker.sv]
// Port-level checks for the sigmoid unit, bound to the top level.
module sfb_checker
	import sfb_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic                  s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic       in_xfer, out_xfer;
	logic [2:0] inflight_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// count transactions inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[15:0] == 16'd0 || m_axis_tdata[31:16] == 16'd0))
		else $error("activation and gradient both nonzero");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more transactions in flight than stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> inflight_q != 3'd0)
		else $error("result without an accepted input");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q == 3'd0 |-> s_axis_tready)
		else $error("input stalled while pipeline empty");

endmodule

bind sigmoid_forward_backward sfb_checker u_sfb_checker (.*);

[tb/sv/sfb_result_checker.sv]
// Result checker for the sigmoid unit: predicts each output and compares it on the master side.
`timescale 1ns / 100ps

module sfb_result_checker
	import sfb_pkg::*;
#(
	parameter int PWL_SEGMENTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// [15:0] x_value, [31:16] saved_output, [47:32] upstream_grad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// [0] action
	input  logic                  s_axis_tuser,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [15:0] activation_out, [31:16] gradient_out
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [15:0] gradient;
		logic [15:0] activation;
	} sfb_result_t;

	localparam logic [63:0] ONE_Q31   = 64'h0000_0000_8000_0000;
	localparam logic [63:0] UNIT_Y    = 64'd65535;
	localparam logic [63:0] UNIT_SQ   = 64'd4294836225;

	logic [31:0]  sigmoid_nodes [0:PWL_SEGMENTS];
	sfb_result_t  predicted_outputs [$];
	sfb_result_t  got;
	sfb_result_t  want;
	int           errors;

	// exp(-t), t in Q31: series at t/256, then square eight times
	function automatic logic [63:0] decay_q31(input logic [63:0] t);
		logic [63:0] u;
		logic [63:0] u2;
		logic [63:0] u3;
		logic [63:0] u4;
		logic [63:0] acc;
		u   = t >> 8;
		u2  = (u * u) >> 31;
		u3  = (u2 * u) >> 31;
		u4  = (u3 * u) >> 31;
		acc = ONE_Q31 - u + u2 / 2 - u3 / 6 + u4 / 24;
		for (int i = 0; i < 8; i++) begin
			acc = (acc * acc) >> 31;
		end
		return acc;
	endfunction

	function automatic logic [15:0] sigmoid_of(input logic [15:0] xb);
		logic        neg;
		logic [31:0] mag;
		logic [31:0] prod;
		logic [31:0] seg;
		logic [31:0] frac;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] slope;
		logic [31:0] s;
		neg  = xb[15];
		mag  = neg ? ((32'h10000 - {16'd0, xb}) & 32'h1FFFF) : {16'd0, xb};
		prod = mag * PWL_SEGMENTS;
		seg  = prod >> 15;
		frac = prod & 32'd32767;
		if (seg >= PWL_SEGMENTS) begin
			s = sigmoid_nodes[PWL_SEGMENTS];
		end else begin
			lo    = sigmoid_nodes[seg];
			hi    = sigmoid_nodes[seg + 1];
			slope = (hi > lo) ? hi - lo : 32'd0;
			s     = lo + ((slope * frac + 32'd16384) >> 15);
		end
		if (s > 32'd65535)
			s = 32'd65535;
		// mirror the negative half
		if (neg)
			s = 32'd65535 - s;
		return s[15:0];
	endfunction

	function automatic logic [15:0] sigmoid_grad_of(input logic [15:0] yb, input logic [15:0] gb);
		logic        neg;
		logic [63:0] mag;
		logic [63:0] slope;
		logic [63:0] q;
		logic [63:0] r;
		neg   = gb[15];
		mag   = neg ? (64'h10000 - {48'd0, gb}) : {48'd0, gb};
		slope = {48'd0, yb} * (UNIT_Y - {48'd0, yb});
		q     = (mag * slope + UNIT_SQ / 2) / UNIT_SQ;
		if (neg) begin
			if (q > 64'd32768)
				q = 64'd32768;
			r = 64'h10000 - q;
		end else begin
			if (q > 64'd32767)
				q = 64'd32767;
			r = q;
		end
		return r[15:0];
	endfunction

	function automatic sfb_result_t predict_result(input logic act, input logic [IN_DATA_W-1:0] d);
		sfb_result_t r;
		if (act == ACT_FWD) begin
			r.activation = sigmoid_of(d[15:0]);
			r.gradient   = 16'd0;
		end else begin
			r.activation = 16'd0;
			r.gradient   = sigmoid_grad_of(d[31:16], d[47:32]);
		end
		return r;
	endfunction

	initial begin
		logic [63:0] t;
		logic [63:0] denom;
		logic [63:0] node;
		for (int k = 0; k <= PWL_SEGMENTS; k++) begin
			t     = ((64'd8 * k) << 31) / PWL_SEGMENTS;
			denom = ONE_Q31 + decay_q31(t);
			node  = ((UNIT_Y << 31) + denom / 2) / denom;
			sigmoid_nodes[k] = node[31:0];
		end
		errors = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predicted_outputs.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (predicted_outputs.size() == 0) begin
					$display("%0t: unexpected result: expected none, got act=%h grad=%h",
						$time, got.activation, got.gradient);
					errors = errors + 1;
				end else begin
					want = predicted_outputs.pop_front();
					if (got.activation !== want.activation) begin
						$display("%0t: activation_out mismatch: expected %h, got %h",
							$time, want.activation, got.activation);
						errors = errors + 1;
					end
					if (got.gradient !== want.gradient) begin
						$display("%0t: gradient_out mismatch: expected %h, got %h",
							$time, want.gradient, got.gradient);
						errors = errors + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predicted_outputs.push_back(predict_result(s_axis_tuser, s_axis_tdata));
		end
		fail_count <= errors;
		pending    <= predicted_outputs.size();
	end

endmodule

[tb/sv/tb_top.sv]
// Testbench top for the sigmoid unit: clock, reset, stream stimulus and the verdict.
`timescale 1ns / 100ps

module tb_top;
	import sfb_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	// [15:0] x_value, [31:16] saved_output, [47:32] upstream_grad
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	// [0] action
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	// [15:0] activation_out, [31:16] gradient_out
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int fail_count;
	int pending;
	int tx_idle;
	int rx_idle;

	sigmoid_forward_backward #(
		.PWL_SEGMENTS(16)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	sfb_result_checker #(
		.PWL_SEGMENTS(16)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("** sigmoid_forward_backward: FAILED **");
		$finish;
	end

	// receiver: stall at random, one decision per cycle
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic send_item(input logic act, input logic [15:0] x,
			input logic [15:0] y, input logic [15:0] g);
		while ($urandom_range(99) < tx_idle) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= act;
		s_axis_tdata  <= {g, y, x};
		// hold until the transaction is taken
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_random();
		logic        act;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] g;
		act = 1'($urandom_range(1));
		x   = 16'($urandom);
		y   = 16'($urandom);
		g   = 16'($urandom);
		case ($urandom_range(3))
			0: begin
				// land on or next to a table node, either sign
				x = 16'($urandom_range(16) * 2048 + $urandom_range(2));
				if ($urandom_range(1))
					x = -x;
			end
			1: begin
				y = 16'($urandom_range(1) ? $urandom_range(7) : 65535 - $urandom_range(7));
			end
			default: ;
		endcase
		send_item(act, x, y, g);
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = ACT_FWD;
		tx_idle       = 27;
		rx_idle       = 68;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// forward extremes, node boundaries, sign mirror
		send_item(ACT_FWD, 16'h0000, 16'h0000, 16'h0000);
		send_item(ACT_FWD, 16'h7FFF, 16'hFFFF, 16'hFFFF);
		send_item(ACT_FWD, 16'h8000, 16'h1234, 16'h8000);
		send_item(ACT_FWD, 16'hFFFF, 16'h0000, 16'h7FFF);
		send_item(ACT_FWD, 16'h0001, 16'hAAAA, 16'h5555);
		send_item(ACT_FWD, 16'h1000, 16'h0000, 16'h0000);
		send_item(ACT_FWD, 16'hF000, 16'h0000, 16'h0000);
		send_item(ACT_FWD, 16'h0800, 16'h0000, 16'h0000);
		send_item(ACT_FWD, 16'hF800, 16'h0000, 16'h0000);
		send_item(ACT_FWD, 16'h2000, 16'h0000, 16'h0000);
		send_item(ACT_FWD, 16'h7800, 16'h0000, 16'h0000);
		// backward: y at the ends and the peak, dy at the extremes
		send_item(ACT_BWD, 16'h5A5A, 16'h0000, 16'h7FFF);
		send_item(ACT_BWD, 16'hFFFF, 16'hFFFF, 16'h8000);
		send_item(ACT_BWD, 16'h8000, 16'h7FFF, 16'h7FFF);
		send_item(ACT_BWD, 16'h7FFF, 16'h8000, 16'h8000);
		send_item(ACT_BWD, 16'h0000, 16'h8000, 16'h7FFF);
		send_item(ACT_BWD, 16'h0000, 16'h7FFF, 16'h8000);
		send_item(ACT_BWD, 16'h0000, 16'h8000, 16'h0000);
		send_item(ACT_BWD, 16'h0000, 16'h8000, 16'hFFFF);
		send_item(ACT_BWD, 16'h0000, 16'h8000, 16'h0001);
		send_item(ACT_BWD, 16'h0000, 16'h0001, 16'h7FFF);
		send_item(ACT_BWD, 16'h0000, 16'hFFFE, 16'h8000);

		repeat (317) send_random();
		tx_idle = 68;
		rx_idle = 27;
		repeat (317) send_random();
		tx_idle = 0;
		rx_idle = 0;
		repeat (316) send_random();

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		// drain, then give stray results time to show up
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("** sigmoid_forward_backward: PASSED **");
		else
			$display("** sigmoid_forward_backward: FAILED **");
		$finish;
	end

endmodule

[sim.f]
sv/sfb_pkg.sv
sv/sigmoid_forward_backward.sv
sv/sfb_checker.sv
tb/sv/sfb_result_checker.sv
tb/sv/tb_top.sv
